[design/rpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared widths, constants and coefficient tables of the range pixel to
// cartesian converter.
// ----------------------------------------------------------------------------
package rpc_pkg;

  // image geometry
  localparam int IMAGE_ROWS = 128;
  localparam int IMAGE_COLS = 128;
  localparam int ROW_W      = $clog2(IMAGE_ROWS);
  localparam int COL_W      = $clog2(IMAGE_COLS);
  localparam int HALF_W     = ((ROW_W > COL_W) ? ROW_W : COL_W) + 2;

  // payload and configuration widths
  localparam int RANGE_W   = 8;
  localparam int MODE_W    = 2;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int FRAC_W    = 8;
  localparam int DIST_W    = RANGE_W + 1;
  localparam int SCALE_W   = DIST_W + FRAC_W;
  localparam int COORD_W   = 17;

  // q30 datapath
  localparam int QF         = 30;
  localparam int MAG_W      = 31;
  localparam int T_W        = 31;
  localparam int PROD_W     = 32;
  localparam int RECIP_W    = 32;
  localparam int ANG_W      = 48;
  localparam int TRIG_STEPS = 7;
  localparam int TRIG_LAT   = 3 * TRIG_STEPS + 2;
  localparam int RAD_W      = 2 * PROD_W;
  localparam int ROOT_W     = PROD_W;
  localparam int NUM_W      = SCALE_W + PROD_W + 1;
  localparam int DIV_STEPS  = COORD_W;

  // scan mode codes, anything else means no slant term
  localparam logic [MODE_W-1:0] MODE_POS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEG  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STANDOFF  = 1'b1;

  localparam logic [CFG_W-1:0] STANDOFF_RST = 8'd10;

  // angle scale factors, q30 radians per half pixel
  localparam logic signed [ANG_W-1:0] KX = 48'sd4392254;
  localparam logic signed [ANG_W-1:0] KY = 48'sd4389394;
  localparam logic signed [ANG_W-1:0] KS = 48'sd22876;
  localparam logic [ANG_W-1:0] ANGLE_MAX = 48'd1610612736;

  localparam logic [T_W-1:0] Q_ONE = T_W'(1) << QF;

  typedef logic [RECIP_W-1:0] coef_t;

  // horner divisors and floor(2^32 / k); a zero divisor marks a pass-through step
  localparam coef_t SIN_DIV [TRIG_STEPS] = '{
    32'd0, 32'd156, 32'd110, 32'd72, 32'd42, 32'd20, 32'd6
  };
  localparam coef_t SIN_RECIP [TRIG_STEPS] = '{
    32'd0, 32'd27531841, 32'd39045157, 32'd59652323, 32'd102261126,
    32'd214748364, 32'd715827882
  };
  localparam coef_t COS_DIV [TRIG_STEPS] = '{
    32'd182, 32'd132, 32'd90, 32'd56, 32'd30, 32'd12, 32'd2
  };
  localparam coef_t COS_RECIP [TRIG_STEPS] = '{
    32'd23598721, 32'd32537631, 32'd47721858, 32'd76695844, 32'd143165576,
    32'd357913941, 32'd2147483648
  };

endpackage

[design/range_pixel_to_cartesian.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_pixel_to_cartesian
// Converts one range pixel (row, column, range) of a scanning laser range
// finder into x, y, z with 8 fraction bits, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  cfg      in         cfg_we              cfg_index, cfg_wdata
//  in       in         in_valid/in_stall   in_row, in_col, in_range_value
//  out      out        out_valid/out_stall out_x_coord, out_y_coord, out_z_coord
//
//  one pixel per cycle while no result is held; 81 register stages from the
//  input transfer to out_valid, output transfer as soon as out_stall is low
//  the pipeline holds the 23-stage trig series, the 32-stage square root
//  (one root bit per stage) and the 17-stage divider (one quotient bit each)
//  reset clears all valid bits, scan_mode to 0 and standoff to 10
//  a held result stalls the whole pipeline; in_stall rises in the same cycle
// ----------------------------------------------------------------------------
module range_pixel_to_cartesian
  import rpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [ROW_W-1:0]          in_row,
  input  logic [COL_W-1:0]          in_col,
  input  logic [RANGE_W-1:0]        in_range_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_x_coord,
  output logic signed [COORD_W-1:0] out_y_coord,
  output logic [COORD_W-1:0]        out_z_coord
);

  // stage map
  localparam int S_IN    = 0;
  localparam int S_PROD  = 1;
  localparam int S_SUM   = 2;
  localparam int S_MAG   = 3;
  localparam int S_TRIG  = S_MAG + TRIG_LAT;
  localparam int S_P1    = S_TRIG + 1;
  localparam int S_P2    = S_P1 + 1;
  localparam int S_P3    = S_P2 + 1;
  localparam int S_ROOT  = S_P3 + ROOT_W;
  localparam int S_DEN   = S_ROOT + 1;
  localparam int S_QUO   = S_DEN + DIV_STEPS;
  localparam int S_OUT   = S_QUO + 1;
  localparam int NSTAGES = S_OUT + 1;

  localparam int LANES  = 3;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;
  localparam int INC_W  = RAD_W + 2;

  localparam logic [COORD_W-1:0] POS_LIM = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] NEG_LIM = {1'b1, {(COORD_W-1){1'b0}}};

  // configuration
  logic [MODE_W-1:0]        scan_mode_r;
  logic [CFG_W-1:0]         standoff_r;

  // control
  logic                     adv;
  logic [NSTAGES-1:0]       vld_r;
  logic [S_QUO:S_MAG]       xneg_r;
  logic [S_QUO:S_MAG]       yneg_r;

  // angle front end
  logic signed [HALF_W-1:0] hc_nxt, hr_nxt, hc_r, hr_r;
  logic [MODE_W-1:0]        mode0_r, mode1_r;
  logic [SCALE_W-1:0]       scale_r [S_IN:S_P1];
  logic signed [ANG_W-1:0]  axp_r, ayr_r, ays_r, ax_r, ay_r;
  logic [ANG_W-1:0]         ax_abs, ay_abs;
  logic [MAG_W-1:0]         magx_r, magy_r;

  // trig and products
  logic [PROD_W-1:0]        sx, cx, sy, cy;
  logic [2*PROD_W-1:0]      p_full, cxcy_full, sxcy_full;
  logic [PROD_W-1:0]        p_r, cxcy_r, sxcy_r, cy_r;
  logic [RAD_W-1:0]         cy2_r, p2_r;

  // square root
  logic [NUM_W-1:0]         num_r  [LANES][S_P2:S_ROOT];
  logic [ROOT_W-1:0]        root_r [S_P3:S_ROOT];
  logic [RAD_W-1:0]         rem_r  [S_P3:S_ROOT];

  // divider
  logic [ROOT_W-1:0]        den_nxt;
  logic [ROOT_W-1:0]        den_r  [S_DEN:S_QUO];
  logic [NUM_W-1:0]         drem_r [LANES][S_DEN:S_QUO];
  logic [COORD_W-1:0]       quo_r  [LANES][S_DEN:S_QUO];

  // output
  logic [COORD_W-1:0]       x_nxt, y_nxt;
  logic [COORD_W-1:0]       x_r, y_r, z_r;

  function automatic logic [COORD_W-1:0] sat_signed(input logic neg,
                                                    input logic [COORD_W-1:0] mag);
    logic [COORD_W-1:0] lim;
    lim = neg ? ((mag > NEG_LIM) ? NEG_LIM : mag) : ((mag > POS_LIM) ? POS_LIM : mag);
    return neg ? COORD_W'(-lim) : lim;
  endfunction

  // whole pipe moves unless a finished result is held
  assign adv      = !vld_r[S_OUT] || !out_stall;
  assign in_stall = !adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_mode_r <= MODE_POS;
      standoff_r  <= STANDOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCAN_MODE: scan_mode_r <= cfg_wdata[MODE_W-1:0];
        REG_STANDOFF:  standoff_r  <= cfg_wdata;
        default:       standoff_r  <= standoff_r;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTAGES-2:0], in_valid};
    end
  end

  // half-pixel offsets from the image center
  assign hc_nxt = HALF_W'({in_col, 1'b0}) - HALF_W'(IMAGE_COLS - 1);
  assign hr_nxt = HALF_W'(IMAGE_ROWS - 1) - HALF_W'({in_row, 1'b0});

  // clamp to +-1.5 rad and split into sign and magnitude
  always_comb begin
    ax_abs = ax_r[ANG_W-1] ? ANG_W'(-ax_r) : ANG_W'(ax_r);
    ay_abs = ay_r[ANG_W-1] ? ANG_W'(-ay_r) : ANG_W'(ay_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // capture
      hc_r           <= hc_nxt;
      hr_r           <= hr_nxt;
      mode0_r        <= scan_mode_r;
      scale_r[S_IN]  <= {DIST_W'(in_range_value) + DIST_W'(standoff_r), FRAC_W'(0)};
      for (int i = S_IN + 1; i <= S_P1; i++) begin
        scale_r[i] <= scale_r[i-1];
      end
      // angle products
      axp_r   <= hc_r * KX;
      ayr_r   <= hr_r * KY;
      ays_r   <= hc_r * KS;
      mode1_r <= mode0_r;
      // slant correction
      ax_r <= axp_r;
      case (mode1_r)
        MODE_POS: ay_r <= ayr_r + ays_r;
        MODE_NEG: ay_r <= ayr_r - ays_r;
        default:  ay_r <= ayr_r;
      endcase
      // magnitudes
      magx_r        <= MAG_W'((ax_abs > ANGLE_MAX) ? ANGLE_MAX : ax_abs);
      magy_r        <= MAG_W'((ay_abs > ANGLE_MAX) ? ANGLE_MAX : ay_abs);
      xneg_r[S_MAG] <= ax_r[ANG_W-1];
      yneg_r[S_MAG] <= ay_r[ANG_W-1];
      xneg_r[S_QUO:S_MAG+1] <= xneg_r[S_QUO-1:S_MAG];
      yneg_r[S_QUO:S_MAG+1] <= yneg_r[S_QUO-1:S_MAG];
    end
  end

  rpc_trig u_trig_x (
    .clk   (clk),
    .en    (adv),
    .mag   (magx_r),
    .sin_q (sx),
    .cos_q (cx)
  );

  rpc_trig u_trig_y (
    .clk   (clk),
    .en    (adv),
    .mag   (magy_r),
    .sin_q (sy),
    .cos_q (cy)
  );

  assign p_full    = sy * cx;
  assign cxcy_full = cx * cy;
  assign sxcy_full = sx * cy;

  always_ff @(posedge clk) begin
    if (adv) begin
      // q30 products
      p_r    <= p_full[QF +: PROD_W];
      cxcy_r <= cxcy_full[QF +: PROD_W];
      sxcy_r <= sxcy_full[QF +: PROD_W];
      cy_r   <= cy;
      // squares and scaled numerators
      cy2_r <= RAD_W'(cy_r) * RAD_W'(cy_r);
      p2_r  <= RAD_W'(p_r) * RAD_W'(p_r);
      num_r[LANE_X][S_P2] <= NUM_W'(scale_r[S_P1]) * NUM_W'(sxcy_r);
      num_r[LANE_Y][S_P2] <= NUM_W'(scale_r[S_P1]) * NUM_W'(p_r);
      num_r[LANE_Z][S_P2] <= NUM_W'(scale_r[S_P1]) * NUM_W'(cxcy_r);
      for (int l = 0; l < LANES; l++) begin
        for (int i = S_P2 + 1; i <= S_ROOT; i++) begin
          num_r[l][i] <= num_r[l][i-1];
        end
      end
      // radicand
      rem_r[S_P3]  <= cy2_r + p2_r;
      root_r[S_P3] <= '0;
    end
  end

  // square root, one result bit per stage
  for (genvar i = S_P3 + 1; i <= S_ROOT; i++) begin : g_sqrt
    localparam int B = S_ROOT - i;
    logic [INC_W-1:0]  inc;
    logic [RAD_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    always_comb begin
      inc = (INC_W'(root_r[i-1]) << (B + 1)) + (INC_W'(1) << (2 * B));
      if (INC_W'(rem_r[i-1]) >= inc) begin
        rem_nxt  = RAD_W'(INC_W'(rem_r[i-1]) - inc);
        root_nxt = root_r[i-1] | (ROOT_W'(1) << B);
      end else begin
        rem_nxt  = rem_r[i-1];
        root_nxt = root_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
      end
    end
  end

  // divisor never below one; add half of it for round to nearest
  assign den_nxt = (root_r[S_ROOT] == '0) ? ROOT_W'(1) : root_r[S_ROOT];

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r[S_DEN] <= den_nxt;
      for (int l = 0; l < LANES; l++) begin
        drem_r[l][S_DEN] <= num_r[l][S_ROOT] + NUM_W'(den_nxt >> 1);
        quo_r[l][S_DEN]  <= '0;
      end
    end
  end

  // restoring divide, three lanes share the divisor
  for (genvar i = S_DEN + 1; i <= S_QUO; i++) begin : g_div
    localparam int B = S_QUO - i;
    logic [NUM_W-1:0] trial;

    assign trial = NUM_W'(den_r[i-1]) << B;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [NUM_W-1:0]   rem_nxt;
      logic [COORD_W-1:0] quo_nxt;

      always_comb begin
        if (drem_r[l][i-1] >= trial) begin
          rem_nxt = drem_r[l][i-1] - trial;
          quo_nxt = quo_r[l][i-1] | (COORD_W'(1) << B);
        end else begin
          rem_nxt = drem_r[l][i-1];
          quo_nxt = quo_r[l][i-1];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          drem_r[l][i] <= rem_nxt;
          quo_r[l][i]  <= quo_nxt;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[i] <= den_r[i-1];
      end
    end
  end

  // sign and saturation
  assign x_nxt = sat_signed(xneg_r[S_QUO], quo_r[LANE_X][S_QUO]);
  assign y_nxt = sat_signed(yneg_r[S_QUO], quo_r[LANE_Y][S_QUO]);

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= quo_r[LANE_Z][S_QUO];
    end
  end

  assign out_valid   = vld_r[S_OUT];
  assign out_x_coord = x_r;
  assign out_y_coord = y_r;
  assign out_z_coord = z_r;

`ifndef NO_ASSERTIONS
  // clamped angles keep both cosines positive
  a_cos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S_TRIG] |-> (cx != '0 && cy != '0))
    else $error("cosine of a valid pixel is zero");

  // every lane ends with a remainder below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S_QUO] |-> (drem_r[LANE_X][S_QUO] < NUM_W'(den_r[S_QUO]) &&
                      drem_r[LANE_Y][S_QUO] < NUM_W'(den_r[S_QUO]) &&
                      drem_r[LANE_Z][S_QUO] < NUM_W'(den_r[S_QUO])))
    else $error("divider remainder not below divisor");

  // a held result freezes every stage
  a_hold_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[S_OUT] && out_stall) |=> $stable(vld_r))
    else $error("pipeline moved while output was held");

  // divisor is at least one
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S_DEN] |-> den_r[S_DEN] != '0)
    else $error("zero divisor");
`endif

endmodule

[design/rpc_trig.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_trig
// Pipelined q30 sine and cosine of an angle magnitude by truncated Horner
// series, three register stages per series term.
// ----------------------------------------------------------------------------
module rpc_trig
  import rpc_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [MAG_W-1:0]  mag,
  output logic [PROD_W-1:0] sin_q,
  output logic [PROD_W-1:0] cos_q
);

  logic [MAG_W-1:0]       m_r  [TRIG_STEPS+1];
  logic [PROD_W-1:0]      a2_r [TRIG_STEPS+1];
  logic [T_W-1:0]         ts_r [TRIG_STEPS+1];
  logic [T_W-1:0]         tc_r [TRIG_STEPS+1];
  logic [2*MAG_W-1:0]     sq;
  logic [MAG_W+T_W-1:0]   sin_prod;
  logic [PROD_W-1:0]      sin_r;
  logic [PROD_W-1:0]      cos_r;

  assign sq = mag * mag;

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]  <= mag;
      a2_r[0] <= sq[QF +: PROD_W];
      ts_r[0] <= Q_ONE;
      tc_r[0] <= Q_ONE;
    end
  end

  for (genvar j = 0; j < TRIG_STEPS; j++) begin : g_step
    logic [MAG_W-1:0]       ma_r, mb_r;
    logic [PROD_W-1:0]      a2a_r, a2b_r;
    logic [T_W-1:0]         tsa_r, tsb_r;
    logic [PROD_W-1:0]      vs_r, vc_r, vsb_r, vcb_r;
    logic [PROD_W-1:0]      qs_r, qc_r;
    logic [PROD_W+T_W-1:0]  ps, pc;
    logic [2*PROD_W-1:0]    es, ec;
    logic [PROD_W-1:0]      cs, cc, rs, rc, ss, sc;
    logic [T_W-1:0]         ts_nxt, tc_nxt;

    // a2 * t
    assign ps = a2_r[j] * ts_r[j];
    assign pc = a2_r[j] * tc_r[j];

    // quotient estimate by reciprocal, low by at most one
    assign es = vs_r * SIN_RECIP[j];
    assign ec = vc_r * COS_RECIP[j];

    always_comb begin
      cs = PROD_W'(qs_r * SIN_DIV[j]);
      cc = PROD_W'(qc_r * COS_DIV[j]);
      rs = vsb_r - cs;
      rc = vcb_r - cc;
      ss = (rs >= SIN_DIV[j]) ? qs_r + 1'b1 : qs_r;
      sc = (rc >= COS_DIV[j]) ? qc_r + 1'b1 : qc_r;
      if (SIN_DIV[j] == '0) begin
        ts_nxt = tsb_r;
      end else if (ss > PROD_W'(Q_ONE)) begin
        ts_nxt = '0;
      end else begin
        ts_nxt = T_W'(PROD_W'(Q_ONE) - ss);
      end
      if (sc > PROD_W'(Q_ONE)) begin
        tc_nxt = '0;
      end else begin
        tc_nxt = T_W'(PROD_W'(Q_ONE) - sc);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ma_r      <= m_r[j];
        a2a_r     <= a2_r[j];
        tsa_r     <= ts_r[j];
        vs_r      <= ps[QF +: PROD_W];
        vc_r      <= pc[QF +: PROD_W];
        mb_r      <= ma_r;
        a2b_r     <= a2a_r;
        tsb_r     <= tsa_r;
        vsb_r     <= vs_r;
        vcb_r     <= vc_r;
        qs_r      <= es[2*PROD_W-1:PROD_W];
        qc_r      <= ec[2*PROD_W-1:PROD_W];
        m_r[j+1]  <= mb_r;
        a2_r[j+1] <= a2b_r;
        ts_r[j+1] <= ts_nxt;
        tc_r[j+1] <= tc_nxt;
      end
    end
  end

  assign sin_prod = m_r[TRIG_STEPS] * ts_r[TRIG_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_prod[QF +: PROD_W];
      cos_r <= PROD_W'(tc_r[TRIG_STEPS]);
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

[bench/tb_range_pixel_to_cartesian.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_pixel_to_cartesian
// Self-checking bench for the range pixel to cartesian converter. Each pixel
// transfer is converted by a bit-level fixed-point copy of the q30 math.
// Every result is checked against the oldest expected point, within 1 lsb,
// under random idling on both channels and several register settings.
// ----------------------------------------------------------------------------
module tb_range_pixel_to_cartesian;
  import rpc_pkg::*;

  // q30 angle steps and limits
  localparam longint ANG_KX  = 4392254;
  localparam longint ANG_KY  = 4389394;
  localparam longint ANG_KS  = 22876;
  localparam longint ANG_LIM = 1610612736;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COORD_W-1:0]        z;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ROW_W-1:0] in_row = '0;
  logic [COL_W-1:0] in_col = '0;
  logic [RANGE_W-1:0] in_range_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_x_coord;
  logic signed [COORD_W-1:0] out_y_coord;
  logic [COORD_W-1:0] out_z_coord;

  range_pixel_to_cartesian dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the configuration registers
  logic [MODE_W-1:0] mode_shadow = MODE_POS;
  logic [7:0] standoff_shadow = STANDOFF_RST;

  point_t expected_points[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;

  // ---------------- fixed-point conversion ----------------
  function automatic logic [63:0] horner_sin(logic [63:0] m);
    logic [63:0] a2, t, sub;
    int divs[6];
    divs = '{156, 110, 72, 42, 20, 6};
    a2 = (m * m) >> 30;
    t = ONE_Q30;
    foreach (divs[i]) begin
      sub = ((a2 * t) >> 30) / divs[i];
      t = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
    end
    return (m * t) >> 30;
  endfunction

  function automatic logic [63:0] horner_cos(logic [63:0] m);
    logic [63:0] a2, t, sub;
    int divs[7];
    divs = '{182, 132, 90, 56, 30, 12, 2};
    a2 = (m * m) >> 30;
    t = ONE_Q30;
    foreach (divs[i]) begin
      sub = ((a2 * t) >> 30) / divs[i];
      t = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
    end
    return t;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint limit_angle(longint a);
    if (a > ANG_LIM) return ANG_LIM;
    if (a < -ANG_LIM) return -ANG_LIM;
    return a;
  endfunction

  function automatic logic signed [COORD_W-1:0] signed_coord(bit neg, logic [63:0] mag);
    if (neg) begin
      if (mag > 65536) mag = 65536;
      return -COORD_W'(mag);
    end
    if (mag > 65535) mag = 65535;
    return COORD_W'(mag);
  endfunction

  function automatic point_t pixel_to_point(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                            logic [RANGE_W-1:0] rng);
    longint hc, hr, slant, ax, ay;
    bit xneg, yneg;
    logic [63:0] mx, my, sx, cx, sy, cy, p, den, scale, z, xm, ym, span;
    point_t pt;
    span = 64'(rng) + 64'(standoff_shadow);
    hc = 2 * longint'(col) - (IMAGE_COLS - 1);
    hr = (IMAGE_ROWS - 1) - 2 * longint'(row);
    slant = (mode_shadow == MODE_POS) ? 1 : (mode_shadow == MODE_NEG) ? -1 : 0;
    ax = limit_angle(hc * ANG_KX);
    ay = limit_angle(hr * ANG_KY + slant * hc * ANG_KS);
    xneg = ax < 0;
    yneg = ay < 0;
    mx = xneg ? -ax : ax;
    my = yneg ? -ay : ay;
    sx = horner_sin(mx);
    cx = horner_cos(mx);
    sy = horner_sin(my);
    cy = horner_cos(my);
    p = (sy * cx) >> 30;
    den = int_sqrt(cy * cy + p * p);
    if (den == 0) den = 1;
    scale = span * 256;
    z  = (scale * ((cx * cy) >> 30) + den / 2) / den;
    xm = (scale * ((sx * cy) >> 30) + den / 2) / den;
    ym = (scale * p + den / 2) / den;
    if (z > 131071) z = 131071;
    pt.x = signed_coord(xneg, xm);
    pt.y = signed_coord(yneg, ym);
    pt.z = z[COORD_W-1:0];
    return pt;
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(string what, int expv, int gotv);
    errors++;
    $display("mismatch %s: expected %0d got %0d at %0t", what, expv, gotv, $realtime);
  endtask

  // the block may round one lsb away from the exact model
  function automatic bit close_enough(int a, int b);
    return (a - b <= 1) && (b - a <= 1);
  endfunction

  always @(posedge clk) begin
    point_t exp_pt;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == REG_SCAN_MODE) mode_shadow <= cfg_wdata[MODE_W-1:0];
        else if (cfg_index == REG_STANDOFF) standoff_shadow <= cfg_wdata;
      end
      if (in_valid && !in_stall)
        expected_points.push_back(pixel_to_point(in_row, in_col, in_range_value));
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected result", 0, 1);
        end else begin
          exp_pt = expected_points.pop_front();
          if (!close_enough(int'(out_x_coord), int'(exp_pt.x)))
            report_mismatch("x_coord", int'(exp_pt.x), int'(out_x_coord));
          if (!close_enough(int'(out_y_coord), int'(exp_pt.y)))
            report_mismatch("y_coord", int'(exp_pt.y), int'(out_y_coord));
          if (!close_enough(int'(out_z_coord), int'(exp_pt.z)))
            report_mismatch("z_coord", int'(exp_pt.z), int'(out_z_coord));
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("range_pixel_to_cartesian regression: fail");
      $finish;
    end
  end

  // receiver: long hold-off first, then random stalls
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic send_pixel(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                            logic [RANGE_W-1:0] rng);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_row <= row;
    in_col <= col;
    in_range_value <= rng;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_points.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random(int count);
    repeat (count) send_pixel(ROW_W'($urandom), COL_W'($urandom), RANGE_W'($urandom));
  endtask

  // ---------------- tests ----------------
  task automatic test_corners();
    logic [6:0] edges[2];
    edges = '{7'd0, 7'd127};
    foreach (edges[r]) foreach (edges[c]) begin
      send_pixel(edges[r], edges[c], 8'd0);
      send_pixel(edges[r], edges[c], 8'd255);
    end
    send_pixel(7'd63, 7'd64, 8'd128);
    send_pixel(7'd64, 7'd63, 8'd1);
  endtask

  task automatic test_scan_modes();
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_SCAN_MODE, CFG_W'(m));
      send_pixel(7'd0, 7'd127, 8'd200);
      send_pixel(7'd127, 7'd0, 8'd200);
      send_pixel(7'd64, 7'd127, 8'd255);
    end
  endtask

  task automatic test_zero_distance();
    write_reg(REG_STANDOFF, 8'd0);
    send_pixel(7'd0, 7'd0, 8'd0);
    send_pixel(7'd127, 7'd127, 8'd0);
    write_reg(REG_STANDOFF, 8'd255);
    send_pixel(7'd0, 7'd0, 8'd255);
    send_pixel(7'd127, 7'd127, 8'd255);
  endtask

  task automatic test_random_phase(int snd, int rcv, int count);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    for (int k = 0; k < 3; k++) begin
      write_reg(REG_SCAN_MODE, CFG_W'($urandom_range(3)));
      write_reg(REG_STANDOFF, (k == 0) ? 8'd0 : (k == 1) ? 8'd255 : CFG_W'($urandom));
      send_random(count / 3);
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 400;
    send_random(250);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_corners();
    test_scan_modes();
    test_zero_distance();
    test_random_phase(36, 61, 600);
    test_random_phase(61, 36, 600);
    test_random_phase(0, 0, 500);
    test_backpressure();
    wait_drained();
    if (errors == 0 && expected_points.size() == 0) begin
      $display("range_pixel_to_cartesian regression: pass");
    end else begin
      $display("range_pixel_to_cartesian regression: fail");
    end
    $finish;
  end

endmodule
